// ===== sv/wspc_pkg.sv =====
`default_nettype none

package wspc_pkg;

    // Field and register widths.
    localparam int SPEED_W   = 18;
    localparam int GAIN_W    = 16;
    localparam int PERIOD_W  = 16;
    localparam int DIVISOR_W = 10;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Rate arithmetic constants.
    localparam logic [SPEED_W-1:0]  STOP_THRESHOLD = 18'd26;
    localparam logic [SPEED_W-1:0]  RATE_NUM       = 18'd256000;
    localparam logic [PERIOD_W-1:0] PERIOD_LIMIT   = 16'd1000;
    localparam logic [15:0]         DUTY_MAX       = 16'hFFFF;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd19661;
    localparam logic [GAIN_W-1:0] INT_GAIN_RST  = 16'd1311;
    localparam logic [GAIN_W-1:0] INT_DECAY_RST = 16'd64881;
    localparam logic [GAIN_W-1:0] INT_LIMIT_RST = 16'd25600;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN = 3'd1;
    localparam logic [2:0] REG_INT_GAIN  = 3'd2;
    localparam logic [2:0] REG_INT_DECAY = 3'd3;
    localparam logic [2:0] REG_INT_LIMIT = 3'd4;

    // Input operation codes.
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_OUT
    } wspc_state_t;

    // Status of a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } wspc_sts_t;

endpackage

`default_nettype wire

// ===== sv/wspc_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant bit first.
module wspc_div
    import wspc_pkg::*;
#(
    parameter int N_W = SPEED_W,
    parameter int D_W = DIVISOR_W
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output wspc_sts_t           sts,
    output logic      [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [D_W-1:0]   rem_reg;
    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   d_reg;

    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;
    logic             fits;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        shifted = {rem_reg, q_reg[N_W-1]};
        diff    = {1'b0, shifted} - {2'b00, d_reg};
        fits    = ~diff[D_W+1];
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
                cnt_reg <= CNT_W'(N_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            d_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[D_W-1:0] : shifted[D_W-1:0];
            q_reg   <= {q_reg[N_W-2:0], fits};
        end
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== sv/wspc_mul.sv =====
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle, least significant first.
module wspc_mul
    import wspc_pkg::*;
#(
    parameter int A_W = GAIN_W,
    parameter int B_W = GAIN_W
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output wspc_sts_t               sts,
    output logic      [A_W+B_W-1:0] prod
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] p_reg;

    logic [A_W-1:0]     addend;
    logic [A_W:0]       upper;

    // Add the multiplicand when the current multiplier bit is set, then shift.
    always_comb
    begin
        addend = p_reg[0] ? a_reg : '0;
        upper  = {1'b0, p_reg[A_W+B_W-1:B_W]} + {1'b0, addend};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
                cnt_reg <= CNT_W'(B_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Partial product register; the low half holds the unused multiplier bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (cnt_reg != '0)
        begin
            p_reg <= {upper, p_reg[B_W-1:1]};
        end
    end

    assign sts.busy = (cnt_reg != '0);
    assign sts.done = done_reg;
    assign prod     = p_reg;

endmodule

`default_nettype wire

// ===== sv/wheel_speed_pi_controller.sv =====
// Wheel speed PI controller. Edge transfers (op 0) carry the milliseconds since the
// previous wheel edge and give no result; the first edge after reset or after a write
// of target_speed only arms the block. Each tick transfer (op 1) gives one result:
// the stored period is turned into a Q.8 rate (256000 / period for periods 1 to 999,
// else 0), the halving average and the leaky, clamped integral are updated, and the
// clamped PI duty is returned. A target below 26 returns stopped with duty 0 and
// leaves the state alone. A tick runs through the 18 steps of the bit-serial divider
// and two rounds of the 16-step bit-serial multipliers; a stop tick goes straight
// to the output. One item is worked on at a time, while a finished result waits in
// the output register. Registers sit at byte addresses 0, 4, 8, 12 and 16; the user
// must write them only while the block is idle, as the block does not enforce it;
// a write of target_speed clears the measurement and integral state.
`default_nettype none

module wheel_speed_pi_controller
    import wspc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic                op,
    input  wire logic [PERIOD_W-1:0] elapsed_ms,

    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic [15:0]              duty,
    output logic                     stopped,
    output logic [SPEED_W-1:0]       speed_now,
    output logic [SPEED_W-1:0]       speed_avg,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // Configuration registers.
    logic [SPEED_W-1:0]  target_reg;
    logic [GAIN_W-1:0]   prop_reg;
    logic [GAIN_W-1:0]   igain_reg;
    logic [GAIN_W-1:0]   decay_reg;
    logic [GAIN_W-1:0]   limit_reg;

    // Controller state.
    logic                armed_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [SPEED_W-1:0]  inst_reg;
    logic [SPEED_W-1:0]  avg_reg;
    logic [GAIN_W-1:0]   integ_reg;

    // Sequencer and working registers.
    wspc_state_t         state_reg, state_next;
    logic                stop_reg, stop_next;
    logic                err_neg_reg;
    logic signed [35:0]  errprop_reg;
    logic [15:0]         duty_res_reg;

    // Output register.
    logic                res_valid_reg;
    logic [15:0]         duty_out_reg;
    logic                stopped_out_reg;
    logic [SPEED_W-1:0]  now_out_reg;
    logic [SPEED_W-1:0]  avg_out_reg;

    // Configuration port decode.
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    // Arithmetic unit connections.
    wspc_sts_t           div_sts;
    wspc_sts_t           mul_a_sts;
    wspc_sts_t           mul_b_sts;
    logic [SPEED_W-1:0]  div_q;
    logic [31:0]         mul_a_prod;
    logic [33:0]         mul_b_prod;
    logic                div_start;
    logic                mul_a_start;
    logic                mul_b_start;
    logic [GAIN_W-1:0]   mul_a_a;
    logic [GAIN_W-1:0]   mul_a_b;

    // Datapath signals.
    logic                period_ok;
    logic [SPEED_W-1:0]  rate_new;
    logic signed [18:0]  err;
    logic [18:0]         err_abs;
    logic [18:0]         avg_sum;
    logic signed [19:0]  isum;
    logic [GAIN_W-1:0]   isum_clamped;
    logic [35:0]         errprop_mag;
    logic signed [35:0]  acc;
    logic [39:0]         scaled;
    logic [15:0]         duty_calc;

    // Sequencer strobes.
    logic                edge_acc;
    logic                div_fin;
    logic                mul1_fin;
    logic                mul2_fin;
    logic                out_load;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    // Register read-back.
    always_comb
    begin
        unique case (cfg_idx)
            REG_TARGET:    prdata = PDATA_W'(target_reg);
            REG_PROP_GAIN: prdata = PDATA_W'(prop_reg);
            REG_INT_GAIN:  prdata = PDATA_W'(igain_reg);
            REG_INT_DECAY: prdata = PDATA_W'(decay_reg);
            REG_INT_LIMIT: prdata = PDATA_W'(limit_reg);
            default:       prdata = '0;
        endcase
    end

    // Rate, error, average and clamped integral sum, taken when the divider finishes.
    always_comb
    begin
        period_ok = (period_reg != '0) && (period_reg < PERIOD_LIMIT);
        rate_new  = period_ok ? div_q : '0;
        err       = $signed({1'b0, target_reg}) - $signed({1'b0, rate_new});
        err_abs   = err[18] ? 19'(-err) : 19'(err);
        avg_sum   = {1'b0, avg_reg} + {1'b0, rate_new};
        isum      = $signed({4'b0000, integ_reg}) + $signed({err[18], err});
        if (isum[19])
            isum_clamped = '0;
        else if (isum[18:0] > {3'b000, limit_reg})
            isum_clamped = limit_reg;
        else
            isum_clamped = isum[15:0];
    end

    // PI sum and duty scaling by 65535 / 2^24.
    always_comb
    begin
        errprop_mag = {2'b00, mul_b_prod};
        acc         = errprop_reg + $signed({4'b0000, mul_a_prod});
        scaled      = {acc[23:0], 16'h0000} - {16'h0000, acc[23:0]};
        if (acc[35] || (acc == '0))
            duty_calc = '0;
        else if (|acc[34:24])
            duty_calc = DUTY_MAX;
        else
            duty_calc = scaled[39:24];
    end

    // Sequencer next state and unit starts.
    always_comb
    begin
        state_next  = state_reg;
        stop_next   = stop_reg;
        item_ready  = 1'b0;
        edge_acc    = 1'b0;
        div_start   = 1'b0;
        div_fin     = 1'b0;
        mul1_fin    = 1'b0;
        mul2_fin    = 1'b0;
        out_load    = 1'b0;
        mul_a_a     = isum_clamped;
        mul_a_b     = decay_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (op == OP_EDGE)
                    begin
                        edge_acc = 1'b1;
                    end
                    else if (target_reg < STOP_THRESHOLD)
                    begin
                        stop_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        stop_next  = 1'b0;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    div_fin    = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                mul_a_a = mul_a_prod[31:16];
                mul_a_b = igain_reg;
                if (mul_a_sts.done)
                begin
                    mul1_fin   = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (mul_a_sts.done)
                begin
                    mul2_fin   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        mul_a_start = div_fin || mul1_fin;
        mul_b_start = div_fin;
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stop_reg  <= stop_next;
        end
    end

    // Configuration and controller state; a target write clears the state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            prop_reg   <= PROP_GAIN_RST;
            igain_reg  <= INT_GAIN_RST;
            decay_reg  <= INT_DECAY_RST;
            limit_reg  <= INT_LIMIT_RST;
            armed_reg  <= 1'b0;
            period_reg <= '0;
            inst_reg   <= '0;
            avg_reg    <= '0;
            integ_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TARGET:
                begin
                    target_reg <= pwdata[SPEED_W-1:0];
                    armed_reg  <= 1'b0;
                    period_reg <= '0;
                    inst_reg   <= '0;
                    avg_reg    <= '0;
                    integ_reg  <= '0;
                end
                REG_PROP_GAIN: prop_reg  <= pwdata[GAIN_W-1:0];
                REG_INT_GAIN:  igain_reg <= pwdata[GAIN_W-1:0];
                REG_INT_DECAY: decay_reg <= pwdata[GAIN_W-1:0];
                REG_INT_LIMIT: limit_reg <= pwdata[GAIN_W-1:0];
                default:       ;
            endcase
        end
        else
        begin
            if (edge_acc)
            begin
                if (!armed_reg)
                    armed_reg <= 1'b1;
                else
                    period_reg <= elapsed_ms;
            end
            if (div_fin)
            begin
                inst_reg <= rate_new;
                avg_reg  <= avg_sum[18:1];
            end
            if (mul1_fin)
                integ_reg <= mul_a_prod[31:16];
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (div_fin)
            err_neg_reg <= err[18];
        if (mul1_fin)
            errprop_reg <= err_neg_reg ? -$signed(errprop_mag) : $signed(errprop_mag);
        if (mul2_fin)
            duty_res_reg <= duty_calc;
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            duty_out_reg    <= stop_reg ? 16'h0000 : duty_res_reg;
            stopped_out_reg <= stop_reg;
            now_out_reg     <= inst_reg;
            avg_out_reg     <= avg_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign duty      = duty_out_reg;
    assign stopped   = stopped_out_reg;
    assign speed_now = now_out_reg;
    assign speed_avg = avg_out_reg;

    // Rate divider: 256000 / period.
    wspc_div #(
        .N_W(SPEED_W),
        .D_W(DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (RATE_NUM),
        .divisor  (period_reg[DIVISOR_W-1:0]),
        .sts      (div_sts),
        .quotient (div_q)
    );

    // Shared multiplier: integral decay, then integral gain.
    wspc_mul #(
        .A_W(GAIN_W),
        .B_W(GAIN_W)
    ) u_mul_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_a_start),
        .a     (mul_a_a),
        .b     (mul_a_b),
        .sts   (mul_a_sts),
        .prod  (mul_a_prod)
    );

    // Error magnitude times proportional gain.
    wspc_mul #(
        .A_W(SPEED_W),
        .B_W(GAIN_W)
    ) u_mul_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_b_start),
        .a     (err_abs[SPEED_W-1:0]),
        .b     (prop_reg),
        .sts   (mul_b_sts),
        .prod  (mul_b_prod)
    );

    // The divider reports completion only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    // Both multipliers start together for the first round and must finish together.
    a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL1) && mul_a_sts.done) |-> mul_b_sts.done)
        else $error("multipliers out of step");

    // A stopped result always carries zero duty.
    a_stop_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && stopped_out_reg) |-> (duty_out_reg == 16'h0000))
        else $error("stopped result with nonzero duty");

    // Any accepted tick, stop or not, blocks further input while it is worked on.
    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (op == OP_TICK)) |=> !item_ready)
        else $error("input taken during tick processing");

    // The reported rate never exceeds the one-millisecond rate.
    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (now_out_reg <= RATE_NUM))
        else $error("instantaneous rate out of range");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    import wspc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that decode to nothing.
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 92;
    localparam int unsigned DRAIN_BOUND   = 20000;
    localparam int unsigned SETTLE_CYCLES = 64;

    // One controller result as it appears on the output ports.
    typedef struct packed {
        logic [15:0]        duty;
        logic               stopped;
        logic [SPEED_W-1:0] speed_now;
        logic [SPEED_W-1:0] speed_avg;
    } loop_result_t;

    // Predicts the speed loop and holds the results it still owes.
    class SpeedLoopScoreboard;
        logic [SPEED_W-1:0]  tgt_speed;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   decay;
        logic [GAIN_W-1:0]   ilimit;

        logic                armed_f;
        logic [PERIOD_W-1:0] period_q;
        logic [SPEED_W-1:0]  rate_now;
        logic [SPEED_W-1:0]  rate_avg;
        logic [15:0]         integ;

        loop_result_t        expected_q[$];
        int unsigned         errors;
        int unsigned         n_edges;
        int unsigned         n_ticks;
        int unsigned         n_stops;
        int unsigned         n_checked;

        function new();
            tgt_speed = '0;
            kp        = PROP_GAIN_RST;
            ki        = INT_GAIN_RST;
            decay     = INT_DECAY_RST;
            ilimit    = INT_LIMIT_RST;
            clear_loop();
            errors    = 0;
            n_edges   = 0;
            n_ticks   = 0;
            n_stops   = 0;
            n_checked = 0;
        endfunction

        function void clear_loop();
            armed_f  = 1'b0;
            period_q = '0;
            rate_now = '0;
            rate_avg = '0;
            integ    = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void flush();
            expected_q.delete();
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // A register write; a target write restarts the measurement.
        function void write_reg(input logic [2:0] idx, input logic [31:0] val);
            case (idx)
                REG_TARGET:
                begin
                    tgt_speed = val[SPEED_W-1:0];
                    clear_loop();
                end
                REG_PROP_GAIN: kp     = val[GAIN_W-1:0];
                REG_INT_GAIN:  ki     = val[GAIN_W-1:0];
                REG_INT_DECAY: decay  = val[GAIN_W-1:0];
                REG_INT_LIMIT: ilimit = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Updates the loop for one accepted input and queues any result.
        function void note_item(input logic op_in, input logic [PERIOD_W-1:0] el);
            loop_result_t r;
            longint err;
            longint sum;
            longint acc;
            longint d;
            if (op_in == OP_EDGE)
            begin
                n_edges++;
                if (!armed_f)
                    armed_f = 1'b1;
                else
                    period_q = el;
                return;
            end
            n_ticks++;
            // Below the stop threshold the loop state is held.
            if (tgt_speed < STOP_THRESHOLD)
            begin
                n_stops++;
                r.duty      = '0;
                r.stopped   = 1'b1;
                r.speed_now = rate_now;
                r.speed_avg = rate_avg;
                expected_q.push_back(r);
                return;
            end
            if (period_q != 0 && period_q < PERIOD_LIMIT)
                rate_now = SPEED_W'(longint'(RATE_NUM) / longint'(period_q));
            else
                rate_now = '0;
            err = longint'(tgt_speed) - longint'(rate_now);
            rate_avg = SPEED_W'((longint'(rate_avg) + longint'(rate_now)) >> 1);
            // Clamped integral, then the leak.
            sum = longint'(integ) + err;
            if (sum < 0)
                sum = 0;
            if (sum > longint'(ilimit))
                sum = longint'(ilimit);
            integ = 16'((sum * longint'(decay)) >> 16);
            acc = err * longint'(kp) + longint'(integ) * longint'(ki);
            if (acc <= 0)
                d = 0;
            else
            begin
                d = (acc * longint'(DUTY_MAX)) >> 24;
                if (d > longint'(DUTY_MAX))
                    d = longint'(DUTY_MAX);
            end
            r.duty      = 16'(d);
            r.stopped   = 1'b0;
            r.speed_now = rate_now;
            r.speed_avg = rate_avg;
            expected_q.push_back(r);
        endfunction

        // Compares one result transfer with the oldest prediction.
        task check_result(input logic [15:0] d, input logic s,
                          input logic [SPEED_W-1:0] sn, input logic [SPEED_W-1:0] sa);
            loop_result_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: duty %0d stopped %0d",
                                          d, s));
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            if (d !== e.duty)
                report_mismatch($sformatf("result %0d: duty %0d, expected %0d",
                                          n_checked, d, e.duty));
            if (s !== e.stopped)
                report_mismatch($sformatf("result %0d: stopped %0d, expected %0d",
                                          n_checked, s, e.stopped));
            if (sn !== e.speed_now)
                report_mismatch($sformatf("result %0d: speed_now %0d, expected %0d",
                                          n_checked, sn, e.speed_now));
            if (sa !== e.speed_avg)
                report_mismatch($sformatf("result %0d: speed_avg %0d, expected %0d",
                                          n_checked, sa, e.speed_avg));
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                item_valid = 1'b0;
    wire logic           item_ready;
    logic                op         = OP_EDGE;
    logic [PERIOD_W-1:0] elapsed_ms = '0;
    wire logic           res_valid;
    logic                res_ready  = 1'b0;
    wire logic [15:0]    duty;
    wire logic           stopped;
    wire logic [SPEED_W-1:0] speed_now;
    wire logic [SPEED_W-1:0] speed_avg;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    wire logic [PDATA_W-1:0] prdata;
    wire logic           pready;

    SpeedLoopScoreboard sb = new();
    logic        quiet = 1'b0;
    int unsigned rx_stall = 0;
    int unsigned n_writes = 0;

    wheel_speed_pi_controller DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .elapsed_ms (elapsed_ms),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .duty       (duty),
        .stopped    (stopped),
        .speed_now  (speed_now),
        .speed_avg  (speed_avg),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 clk = ~clk;

    // Result side: check each transfer, then hold off ready for a random stall, none when quiet.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                sb.check_result(duty, stopped, speed_now, speed_avg);
                rx_stall = quiet ? 0 : $urandom_range(0, 3);
            end
            else if (res_valid && rx_stall > 0)
                rx_stall--;
            res_ready <= (rx_stall == 0);
        end
    end

    // Backstop against a hung block.
    initial
    begin
        #(10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [PERIOD_W-1:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return PERIOD_W'($urandom_range(1000, 65535));
        else if (r == 2)
            return PERIOD_W'($urandom);
        else if (r == 3)
            return PERIOD_W'($urandom_range(1, 12));
        return PERIOD_W'($urandom_range(1, 999));
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return GAIN_W'($urandom);
    endfunction

    // One input transfer, after a random gap unless the phase is quiet.
    task automatic send_item(input logic op_in, input logic [PERIOD_W-1:0] el);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= op_in;
        elapsed_ms <= el;
        do @(posedge clk); while (!item_ready);
        sb.note_item(op_in, el);
    endtask

    // Waits until every predicted result has arrived, then lets the block settle.
    task automatic drain_results();
        int unsigned waited;
        item_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_BOUND)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
            sb.flush();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then back to idle.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        n_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // New random gains and target for one phase; the target goes last since it clears state.
    task automatic configure_phase();
        logic [SPEED_W-1:0] tgt;
        int unsigned r;
        reg_write(REG_PROP_GAIN, {16'($urandom), pick_gain()});
        reg_write(REG_INT_GAIN,  {16'($urandom), pick_gain()});
        reg_write(REG_INT_DECAY, {16'($urandom), pick_gain()});
        reg_write(REG_INT_LIMIT, {16'($urandom), pick_gain()});
        if ($urandom_range(0, 3) == 0)
            reg_write(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
        r = $urandom_range(0, 7);
        if (r == 0)
            tgt = SPEED_W'($urandom_range(0, 25));
        else if (r == 1)
            tgt = SPEED_W'($urandom_range(25601, 262143));
        else
            tgt = SPEED_W'($urandom_range(26, 25600));
        reg_write(REG_TARGET, {14'($urandom), tgt});
    endtask

    initial
    begin
        int unsigned count;
        int unsigned k;
        logic        paused;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: target 0 stops the loop; unarmed edge, then a zero period.
        send_item(OP_TICK, '0);
        send_item(OP_EDGE, '1);
        send_item(OP_EDGE, '0);
        send_item(OP_TICK, '1);

        // Just below the stop threshold.
        drain_results();
        reg_write(REG_TARGET, 32'd25);
        send_item(OP_EDGE, 16'd40);
        send_item(OP_TICK, '0);

        // Just at the threshold, shortest, longest valid and too-long periods.
        drain_results();
        reg_write(REG_TARGET, 32'd26);
        send_item(OP_EDGE, 16'd500);
        send_item(OP_EDGE, 16'd1);
        send_item(OP_TICK, '0);
        send_item(OP_EDGE, 16'd999);
        send_item(OP_TICK, '0);
        send_item(OP_EDGE, 16'd1000);
        send_item(OP_TICK, '0);
        send_item(OP_EDGE, '1);
        send_item(OP_TICK, '0);

        // Every register at its top, target beyond the rate range.
        drain_results();
        reg_write(REG_PROP_GAIN, 32'h0000_FFFF);
        reg_write(REG_INT_GAIN,  32'h0000_FFFF);
        reg_write(REG_INT_DECAY, 32'h0000_FFFF);
        reg_write(REG_INT_LIMIT, 32'h0000_FFFF);
        reg_write(REG_TARGET,    32'h0003_FFFF);
        send_item(OP_EDGE, '0);
        send_item(OP_EDGE, 16'd2);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);

        // Every register but the target at zero, plus writes to unused indexes.
        drain_results();
        reg_write(REG_PROP_GAIN, 32'hFFFF_0000);
        reg_write(REG_INT_GAIN,  '0);
        reg_write(REG_INT_DECAY, '0);
        reg_write(REG_INT_LIMIT, '0);
        reg_write(REG_UNUSED_LO, '1);
        reg_write(REG_UNUSED_HI, '1);
        reg_write(REG_TARGET,    32'd6400);
        send_item(OP_EDGE, 16'd10);
        send_item(OP_EDGE, 16'd10);
        send_item(OP_TICK, '0);

        // Random phases: mostly edge-then-tick sequences, some noise.
        paused = 1'b0;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            quiet = (phase == 3);
            configure_phase();
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                // Hold the sender until the block has delivered everything.
                if (phase == 1 && !paused && count >= PHASE_ITEMS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 8)
                begin
                    k = $urandom_range(1, 2);
                    repeat (k)
                    begin
                        send_item(OP_EDGE, pick_period());
                        count++;
                    end
                    k = $urandom_range(1, 2);
                    repeat (k)
                    begin
                        send_item(OP_TICK, PERIOD_W'($urandom));
                        count++;
                    end
                end
                else
                begin
                    send_item(1'($urandom), PERIOD_W'($urandom));
                    count++;
                end
            end
        end
        quiet = 1'b0;
        drain_results();

        $display("Run covered %0d edge and %0d tick transfers (%0d while stopped),",
                 sb.n_edges, sb.n_ticks, sb.n_stops);
        $display("%0d results checked and %0d register writes over %0d random phases.",
                 sb.n_checked, n_writes, RANDOM_PHASES);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
